/* hdl/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// Color palette register package
// Port codes, color component codes and the default sixteen-color table.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned SmallDepth = 32;
  localparam int unsigned LargeDepth = 256;
  localparam int unsigned DigDepth   = 8;

  localparam logic [3:0] PortCode   = 4'd0;
  localparam logic [3:0] PortBlue   = 4'd1;
  localparam logic [3:0] PortRed    = 4'd2;
  localparam logic [3:0] PortGreen  = 4'd3;
  localparam logic [3:0] PortDig0   = 4'd4;
  localparam logic [3:0] PortDig7   = 4'd11;
  localparam logic [3:0] PortStatus = 4'd12;

  localparam logic KindRead  = 1'b0;
  localparam logic KindWrite = 1'b1;

  localparam logic [7:0] UnknownByte = 8'hFF;
  localparam logic [7:0] FlagByte    = 8'h80;

  typedef enum logic [1:0] {
    CompRed   = 2'd0,
    CompGreen = 2'd1,
    CompBlue  = 2'd2
  } comp_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  function automatic color_t default_color(input logic [3:0] idx);
    color_t c;
    logic [7:0] lvl;
    lvl = idx[3] ? 8'hFF : 8'h80;
    c.r = idx[1] ? lvl : 8'h00;
    c.g = idx[2] ? lvl : 8'h00;
    c.b = idx[0] ? lvl : 8'h00;
    if (idx[2:0] == 3'd0) begin
      c = '0;
    end
    return c;
  endfunction

endpackage

/* hdl/color_palette_registers_unit.sv */
// ----------------------------------------------------------------------------
// Color palette register unit
// Byte-wide register port with an index latch, a two-page sixteen-color
// palette, a 256-entry color table and eight digital palette entries.
// ----------------------------------------------------------------------------
// An accepted item's result is in the output register in the next cycle.
// Throughput: one item per cycle while not stalled; the output register holds under stall.
// The 256-entry table is a memory with registered read data, read on accept.
// Reset: all control state resets asynchronously; small palette and digital
// entries load their defaults, then a clearing pass writes FF to every table
// entry while the input is stalled.
module color_palette_registers_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [3:0] port_i,
  input  logic [7:0] write_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_byte_o
);
  import cpr_pkg::*;

  logic [1:0] sel_q;
  logic [7:0] idx_q;
  logic       flag_q;
  logic [3:0] dig_q [DigDepth];
  color_t     sm_q [SmallDepth];

  logic [7:0] mem_r [LargeDepth];
  logic [7:0] mem_g [LargeDepth];
  logic [7:0] mem_b [LargeDepth];
  logic [7:0] rd_r_q, rd_g_q, rd_b_q;

  logic       clr_busy_q;
  logic [7:0] clr_addr_q;
  logic [7:0] mem_addr;
  logic [7:0] mem_wdata;
  logic       mem_we_r, mem_we_g, mem_we_b;

  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       use_mem_q, use_mem_d;
  comp_e      comp_q, comp;

  logic       in_fire;
  logic       is_small;
  logic [4:0] sm_addr;
  logic [2:0] dig_idx;
  logic [7:0] nib_byte;
  logic [7:0] sm_byte;
  logic       is_code, is_comp, is_dig, is_stat;
  logic       wr;
  logic       lg_we_r, lg_we_g, lg_we_b;
  logic [7:0] rd_sel;

  assign in_stall_o = clr_busy_q | (out_valid_q & out_stall_i);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign wr         = in_fire & (kind_i == KindWrite);

  assign is_small = ~sel_q[0];
  assign sm_addr  = {sel_q[1], idx_q[3:0]};
  assign dig_idx  = 3'(port_i - PortDig0);
  assign nib_byte = {write_byte_i[7:4], write_byte_i[7:4]};

  assign is_code = (port_i == PortCode);
  assign is_comp = (port_i >= PortBlue) && (port_i <= PortGreen);
  assign is_dig  = (port_i >= PortDig0) && (port_i <= PortDig7);
  assign is_stat = (port_i == PortStatus);

  always_comb begin
    priority if (port_i == PortBlue) begin
      comp = CompBlue;
    end else if (port_i == PortRed) begin
      comp = CompRed;
    end else begin
      comp = CompGreen;
    end
  end

  always_comb begin
    unique case (comp)
      CompRed:   sm_byte = sm_q[sm_addr].r;
      CompGreen: sm_byte = sm_q[sm_addr].g;
      CompBlue:  sm_byte = sm_q[sm_addr].b;
      default:   sm_byte = sm_q[sm_addr].g;
    endcase
  end

  assign lg_we_r = wr & is_comp & ~is_small & (comp == CompRed);
  assign lg_we_g = wr & is_comp & ~is_small & (comp == CompGreen);
  assign lg_we_b = wr & is_comp & ~is_small & (comp == CompBlue);

  assign mem_addr  = clr_busy_q ? clr_addr_q : idx_q;
  assign mem_wdata = clr_busy_q ? 8'hFF : write_byte_i;
  assign mem_we_r  = clr_busy_q | lg_we_r;
  assign mem_we_g  = clr_busy_q | lg_we_g;
  assign mem_we_b  = clr_busy_q | lg_we_b;

  always_comb begin
    byte_d    = 8'h00;
    use_mem_d = 1'b0;
    if (kind_i == KindRead) begin
      priority if (is_code) begin
        byte_d = idx_q;
      end else if (is_comp) begin
        byte_d    = sm_byte;
        use_mem_d = ~is_small;
      end else if (is_dig) begin
        byte_d = {4'h0, dig_q[dig_idx]};
      end else if (is_stat) begin
        byte_d = flag_q ? FlagByte : 8'h00;
      end else begin
        byte_d = UnknownByte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= 2'd0;
      idx_q      <= 8'h00;
      flag_q     <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= 8'h00;
      for (int i = 0; i < DigDepth; i++) begin
        dig_q[i] <= 4'(i);
      end
      for (int i = 0; i < SmallDepth; i++) begin
        sm_q[i] <= default_color(4'(i));
      end
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 8'd1;
        if (clr_addr_q == 8'hFF) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (cfg_we_i) begin
        sel_q <= cfg_wdata_i;
      end
      if (wr && is_code) begin
        idx_q <= write_byte_i;
      end
      if (wr && is_dig) begin
        dig_q[dig_idx] <= write_byte_i[3:0];
      end
      if (wr && is_dig) begin
        flag_q <= 1'b1;
      end else if (in_fire && (kind_i == KindRead) && is_stat) begin
        flag_q <= 1'b0;
      end
      if (wr && is_comp && is_small) begin
        unique case (comp)
          CompRed:   sm_q[sm_addr].r <= nib_byte;
          CompGreen: sm_q[sm_addr].g <= nib_byte;
          CompBlue:  sm_q[sm_addr].b <= nib_byte;
          default:   sm_q[sm_addr].g <= nib_byte;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_r) mem_r[mem_addr] <= mem_wdata;
    if (mem_we_g) mem_g[mem_addr] <= mem_wdata;
    if (mem_we_b) mem_b[mem_addr] <= mem_wdata;
    if (in_fire) begin
      rd_r_q <= mem_r[idx_q];
      rd_g_q <= mem_g[idx_q];
      rd_b_q <= mem_b[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q    <= byte_d;
      use_mem_q <= use_mem_d;
      comp_q    <= comp;
    end
  end

  always_comb begin
    unique case (comp_q)
      CompRed:   rd_sel = rd_r_q;
      CompGreen: rd_sel = rd_g_q;
      CompBlue:  rd_sel = rd_b_q;
      default:   rd_sel = rd_g_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign read_byte_o = use_mem_q ? rd_sel : byte_q;

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("Accepted item produced no result.");

  a_status_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (kind_i == KindRead) && is_stat) |=> !flag_q)
    else $error("Status read did not clear the mode flag.");

  a_dig_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && is_dig) |=> flag_q)
    else $error("Digital entry write did not set the mode flag.");

  a_code_loads_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && is_code) |=> (idx_q == $past(write_byte_i)))
    else $error("Code write did not load the index latch.");

endmodule
